// File: hdl/mtnc_pkg.sv
package mtnc_pkg;

  // stack and name limits
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned MAX_NAME    = 32;

  // derived widths
  localparam int unsigned SP_W      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned POS_W     = $clog2(MAX_NAME + 1);
  localparam int unsigned SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned RAM_DEPTH = STACK_DEPTH * MAX_NAME;
  localparam int unsigned ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  // character codes
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  // one character beat as seen by the checker core
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } step_t;

  // name store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  function automatic logic is_alnum(logic [7:0] c);
    return (c inside {[CH_0:CH_9]}) || (c inside {[CH_UA:CH_UZ]}) ||
           (c inside {[CH_LA:CH_LZ]});
  endfunction

endpackage

// File: hdl/mtnc_name_ram.sv
module mtnc_name_ram (
  input  logic                         clk_i,
  input  mtnc_pkg::ram_wr_t            wr_i,
  input  logic [mtnc_pkg::ADDR_W-1:0]  rd_addr_i,
  output logic [7:0]                   rd_data_o
);

  logic [7:0] mem_q [mtnc_pkg::RAM_DEPTH];
  logic [7:0] rd_data_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/mtnc_core.sv
module mtnc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_valid_i,
  input  mtnc_pkg::step_t     step_i,
  output logic                verdict_o
);

  logic [mtnc_pkg::SP_W-1:0]   sp_q, sp_d;
  logic [mtnc_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                        inside_q, inside_d;
  logic                        slash_q, slash_d;
  logic                        err_q, err_d;
  logic                        tm_q, tm_d;
  logic                        pend_q, pend_d;
  logic                        pend_cmp_q, pend_cmp_d;
  logic [7:0]                  pend_ch_q, pend_ch_d;
  logic [mtnc_pkg::POS_W-1:0]  len_q [mtnc_pkg::STACK_DEPTH];
  logic                        len_we;
  logic [mtnc_pkg::SLOT_W-1:0] top_slot;
  logic [mtnc_pkg::SLOT_W-1:0] cur_slot;
  logic [mtnc_pkg::POS_W-1:0]  top_len;
  logic [7:0]                  rd_data;
  logic [mtnc_pkg::ADDR_W-1:0] rd_addr;
  mtnc_pkg::ram_wr_t           ram_wr;
  logic                        mismatch_now;
  logic                        tm_eff;
  logic                        stack_empty;
  logic                        stack_full;

  // slot addressing
  assign cur_slot    = sp_q[mtnc_pkg::SLOT_W-1:0];
  assign top_slot    = mtnc_pkg::SLOT_W'(sp_q - mtnc_pkg::SP_W'(1));
  assign top_len     = len_q[top_slot];
  assign stack_empty = (sp_q == '0);
  assign stack_full  = (sp_q >= mtnc_pkg::SP_W'(mtnc_pkg::STACK_DEPTH));
  assign rd_addr     = mtnc_pkg::ADDR_W'(top_slot) * mtnc_pkg::ADDR_W'(mtnc_pkg::MAX_NAME)
                     + mtnc_pkg::ADDR_W'(pos_q);

  // compare of the previous name character against the top entry
  assign mismatch_now = pend_q && pend_cmp_q && (rd_data != pend_ch_q);
  assign tm_eff       = tm_q | mismatch_now;

  mtnc_name_ram u_name_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // tag parser and stack control
  always_comb begin
    sp_d       = sp_q;
    pos_d      = pos_q;
    inside_d   = inside_q;
    slash_d    = slash_q;
    err_d      = err_q;
    tm_d       = tm_eff;
    pend_d     = 1'b0;
    pend_cmp_d = pend_cmp_q;
    pend_ch_d  = pend_ch_q;
    len_we     = 1'b0;
    verdict_o  = !err_q && !inside_q && stack_empty;
    ram_wr.en   = 1'b0;
    ram_wr.addr = mtnc_pkg::ADDR_W'(cur_slot) * mtnc_pkg::ADDR_W'(mtnc_pkg::MAX_NAME)
                + mtnc_pkg::ADDR_W'(pos_q);
    ram_wr.data = step_i.ch;
    if (step_valid_i) begin
      if (step_i.eoi) begin
        sp_d     = '0;
        pos_d    = '0;
        inside_d = 1'b0;
        slash_d  = 1'b0;
        err_d    = 1'b0;
        tm_d     = 1'b0;
      end else if (!err_q) begin
        if (!inside_q) begin
          if (step_i.ch == mtnc_pkg::CH_LT) begin
            inside_d = 1'b1;
            slash_d  = 1'b0;
            pos_d    = '0;
            tm_d     = 1'b0;
          end else if (step_i.ch == mtnc_pkg::CH_GT) begin
            err_d = 1'b1;
          end
        end else begin
          case (step_i.ch)
            mtnc_pkg::CH_GT: begin
              inside_d = 1'b0;
              if (!slash_q) begin
                if (stack_full) begin
                  err_d = 1'b1;
                end else begin
                  len_we = 1'b1;
                  sp_d   = sp_q + mtnc_pkg::SP_W'(1);
                end
              end else if (stack_empty || tm_eff || pos_q != top_len) begin
                err_d = 1'b1;
              end else begin
                sp_d = sp_q - mtnc_pkg::SP_W'(1);
              end
            end
            mtnc_pkg::CH_SLASH: begin
              if (slash_q) begin
                err_d = 1'b1;
              end else begin
                slash_d = 1'b1;
              end
            end
            default: begin
              if (!mtnc_pkg::is_alnum(step_i.ch)) begin
                err_d = 1'b1;
              end else if (pos_q >= mtnc_pkg::POS_W'(mtnc_pkg::MAX_NAME)) begin
                err_d = 1'b1;
              end else begin
                ram_wr.en  = !stack_full;
                pend_d     = 1'b1;
                pend_cmp_d = !stack_empty && (pos_q < top_len);
                pend_ch_d  = step_i.ch;
                pos_d      = pos_q + mtnc_pkg::POS_W'(1);
              end
            end
          endcase
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      pos_q    <= '0;
      inside_q <= 1'b0;
      slash_q  <= 1'b0;
      err_q    <= 1'b0;
      tm_q     <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      sp_q     <= sp_d;
      pos_q    <= pos_d;
      inside_q <= inside_d;
      slash_q  <= slash_d;
      err_q    <= err_d;
      tm_q     <= tm_d;
      pend_q   <= pend_d;
    end
  end

  // pending compare payload and name lengths
  always_ff @(posedge clk_i) begin
    pend_cmp_q <= pend_cmp_d;
    pend_ch_q  <= pend_ch_d;
    if (len_we) begin
      len_q[cur_slot] <= pos_q;
    end
  end

  // checks
  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= mtnc_pkg::SP_W'(mtnc_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mtnc_pkg::POS_W'(mtnc_pkg::MAX_NAME))
    else $error("name position beyond limit");

  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && step_i.eoi |=> sp_q == '0 && !err_q && !inside_q && !pend_q)
    else $error("state not cleared after end of document");

  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && step_valid_i && !step_i.eoi |=> $stable(sp_q) && err_q)
    else $error("stack moved after error");

endmodule

// File: hdl/markup_tag_nesting_checker.sv
// markup tag nesting checker
//
// input stream: one character per beat on s_axis; tdata[7:0] carries the
// byte, tlast marks the end of a document (its byte is ignored). Tags are
// parsed as they arrive, names are pushed on a 16-entry stack of 32-byte
// names, and closing names are compared byte by byte against the top entry.
// output stream: one beat per document on m_axis, tdata[0] is 1 when every
// tag was well formed and balanced.
// throughput: one character per cycle, sustained, also while the result
// register holds an unread verdict; only an end-of-document beat waits for
// that register to drain.
// verdict path: a taken tlast beat passes the input register, then the parse
// logic into the result register, which drives m_axis. Name bytes are
// compared in the cycle after they arrive, through the registered name
// store read, and the pending compare is merged at the closing '>'.
// reset: clears parser state, stack pointer and both stream registers; the
// name store needs no clearing since only pushed entries are ever compared.
// stall: when m_axis_tready is low the verdict holds and characters of the
// next document keep flowing until its own tlast arrives.
module markup_tag_nesting_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] ch
  input  logic       s_axis_tlast_i,  // end_of_input
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] document_valid, [7:1] zero
);

  logic            in_valid_q;
  mtnc_pkg::step_t in_q;
  logic            out_valid_q;
  logic            out_data_q;
  logic            advance;
  logic            verdict;

  // a character always moves on; an end beat needs the result register free
  assign advance = in_valid_q && !(in_q.eoi && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.ch  <= s_axis_tdata_i;
      in_q.eoi <= s_axis_tlast_i;
    end
  end

  mtnc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (advance),
    .step_i       (in_q),
    .verdict_o    (verdict)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.eoi) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.eoi) begin
      out_data_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_data_q};

endmodule
